// ===== design/dec2fix_pkg.sv =====
// Shared widths, constants and character codes for the decimal field converter.
`default_nettype none
package dec2fix_pkg;

  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned CharWidth         = 8;
  localparam int unsigned FracWidth         = 4;
  localparam int unsigned OutValueWidth     = 32;
  localparam int unsigned OutDataWidth      = 40;

  localparam logic [FracWidth-1:0] MaxFracReset = 4'd5;
  localparam logic [FracWidth-1:0] MaxFracLimit = 4'd9;

  localparam logic [CharWidth-1:0] CharComma    = 8'h2C;
  localparam logic [CharWidth-1:0] CharAsterisk = 8'h2A;
  localparam logic [CharWidth-1:0] CharSpace    = 8'h20;
  localparam logic [CharWidth-1:0] CharCr       = 8'h0D;
  localparam logic [CharWidth-1:0] CharNul      = 8'h00;
  localparam logic [CharWidth-1:0] CharMinus    = 8'h2D;
  localparam logic [CharWidth-1:0] CharPoint    = 8'h2E;
  localparam logic [CharWidth-1:0] CharZero     = 8'h30;
  localparam logic [CharWidth-1:0] CharNine     = 8'h39;

  function automatic logic is_terminator(input logic [CharWidth-1:0] c);
    return (c == CharComma) || (c == CharAsterisk) || (c == CharSpace) ||
           (c == CharCr) || (c == CharNul);
  endfunction

endpackage
`default_nettype wire

// ===== design/decimal_field_to_fixed_point_top.sv =====
// Top level: ASCII decimal field to scaled signed integer converter.
// A registered result reaches the master side in the cycle after its terminating transfer.
// One character per cycle; the accumulator multiply-by-ten and add is combinational.
// The slave side stalls only while a finished result waits on a stalled master side.
// Reset: asynchronous, active low; clears the field state, the result valid and
// sets the fraction digit limit to five.
`default_nettype none
module decimal_field_to_fixed_point_top #(
  parameter int unsigned VALUE_WIDTH = dec2fix_pkg::ValueWidthDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [dec2fix_pkg::FracWidth-1:0]     cfg_wdata_i,
  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,
  // [7:0] character
  input  wire logic [dec2fix_pkg::CharWidth-1:0]     s_axis_tdata,
  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // [31:0] value, [35:32] fraction_digits, [39:36] zero
  output      logic [dec2fix_pkg::OutDataWidth-1:0]  m_axis_tdata,
  // [0] invalid
  output      logic                                  m_axis_tuser
);

  localparam int unsigned FW = dec2fix_pkg::FracWidth;
  localparam int unsigned CW = dec2fix_pkg::CharWidth;
  localparam int unsigned OW = dec2fix_pkg::OutValueWidth;

  logic [FW-1:0]          max_frac_q;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [FW-1:0]          frac_q, frac_d;
  logic                   neg_q, neg_d;
  logic                   point_q, point_d;
  logic                   any_q, any_d;
  logic                   disc_q, disc_d;

  logic                   out_valid_q, out_valid_d;
  logic [OW-1:0]          out_value_q, out_value_d;
  logic [FW-1:0]          out_frac_q, out_frac_d;
  logic                   out_inv_q, out_inv_d;

  logic                   in_xfer;
  logic                   out_xfer;
  logic [CW-1:0]          c;
  logic                   is_term;
  logic                   is_digit;
  logic [VALUE_WIDTH-1:0] acc_mac;
  logic [VALUE_WIDTH-1:0] acc_signed;
  logic [OW-1:0]          acc_ext;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  assign c        = s_axis_tdata;
  assign is_term  = dec2fix_pkg::is_terminator(c);
  assign is_digit = (c >= dec2fix_pkg::CharZero) && (c <= dec2fix_pkg::CharNine);

  assign acc_mac = {acc_q[VALUE_WIDTH-4:0], 3'b000} + {acc_q[VALUE_WIDTH-2:0], 1'b0}
                 + VALUE_WIDTH'(c[3:0]);
  assign acc_signed = neg_q ? (VALUE_WIDTH'(0) - acc_q) : acc_q;
  assign acc_ext    = OW'(acc_signed);

  always_comb begin
    acc_d       = acc_q;
    frac_d      = frac_q;
    neg_d       = neg_q;
    point_d     = point_q;
    any_d       = any_q;
    disc_d      = disc_q;
    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    out_value_d = out_value_q;
    out_frac_d  = out_frac_q;
    out_inv_d   = out_inv_q;
    if (in_xfer) begin
      if (disc_q) begin
        if (is_term) begin
          disc_d = 1'b0;
        end
      end else if (is_term) begin
        out_valid_d = 1'b1;
        out_value_d = acc_ext;
        out_frac_d  = frac_q;
        out_inv_d   = 1'b0;
        acc_d       = '0;
        frac_d      = '0;
        neg_d       = 1'b0;
        point_d     = 1'b0;
        any_d       = 1'b0;
      end else if (is_digit) begin
        any_d = 1'b1;
        if (!point_q) begin
          acc_d = acc_mac;
        end else if (frac_q < max_frac_q) begin
          acc_d  = acc_mac;
          frac_d = frac_q + FW'(1);
        end
      end else if ((c == dec2fix_pkg::CharMinus) && !any_q) begin
        neg_d = 1'b1;
        any_d = 1'b1;
      end else if ((c == dec2fix_pkg::CharPoint) && !point_q) begin
        point_d = 1'b1;
        any_d   = 1'b1;
      end else begin
        out_valid_d = 1'b1;
        out_value_d = '0;
        out_frac_d  = '0;
        out_inv_d   = 1'b1;
        acc_d       = '0;
        frac_d      = '0;
        neg_d       = 1'b0;
        point_d     = 1'b0;
        any_d       = 1'b0;
        disc_d      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frac_q  <= dec2fix_pkg::MaxFracReset;
      acc_q       <= '0;
      frac_q      <= '0;
      neg_q       <= 1'b0;
      point_q     <= 1'b0;
      any_q       <= 1'b0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_frac_q <= (cfg_wdata_i > dec2fix_pkg::MaxFracLimit) ?
                      dec2fix_pkg::MaxFracLimit : cfg_wdata_i;
      end
      acc_q       <= acc_d;
      frac_q      <= frac_d;
      neg_q       <= neg_d;
      point_q     <= point_d;
      any_q       <= any_d;
      disc_q      <= disc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_frac_q  <= out_frac_d;
    out_inv_q   <= out_inv_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(dec2fix_pkg::OutDataWidth - OW - FW){1'b0}}, out_frac_q, out_value_q};
  assign m_axis_tuser  = out_inv_q;

  a_max_frac_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_frac_q <= dec2fix_pkg::MaxFracLimit)
    else $error("fraction digit limit above nine");

  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_q <= dec2fix_pkg::MaxFracLimit)
    else $error("fraction count above nine");

  a_frac_needs_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frac_q != '0) |-> point_q)
    else $error("fraction digits counted without a point");

  a_discard_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> ((acc_q == '0) && !any_q && !neg_q && !point_q))
    else $error("field state not cleared while discarding");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_inv_q) |-> ((out_value_q == '0) && (out_frac_q == '0)))
    else $error("invalid result carries nonzero data");

endmodule
`default_nettype wire
